// ===== design/moving_median_filter_assert.svh =====
// assertion macros for the moving median filter
`ifndef MOVING_MEDIAN_FILTER_ASSERT_SVH
`define MOVING_MEDIAN_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define MMF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("moving median filter check failed");
`define MMF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("moving median filter check failed");
`else
`define MMF_ASSERT(lbl, clk, rst_n, prop)
`define MMF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/mmf_pkg.sv =====
// shared constants, types and helpers of the moving median filter
package mmf_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned WIN_CFG_BITS    = 6;
  localparam int unsigned MIN_WINDOW      = 3;

  typedef struct packed {
    logic clear;
    logic step;
  } node_ctl_t;

  function automatic int unsigned win_clamp(logic [WIN_CFG_BITS-1:0] w, int unsigned max_w);
    int unsigned n;
    n = int'(w);
    if (n < MIN_WINDOW) n = MIN_WINDOW;
    if (n > max_w) n = max_w;
    return n;
  endfunction

endpackage

// ===== design/mmf_node.sv =====
// one sorted window slot: drops the oldest entry and inserts the new sample
module mmf_node #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned AGE_BITS    = 5,
  parameter int unsigned N_BITS      = 6,
  parameter int unsigned IDX         = 0
) (
  input  logic                          clk,
  input  mmf_pkg::node_ctl_t            ctl,
  input  logic [N_BITS-1:0]             n_eff,
  input  logic [N_BITS-1:0]             n_init,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] prev_rem_v,
  input  logic [AGE_BITS-1:0]           prev_rem_age,
  input  logic                          prev_g,
  input  logic                          prev_d,
  input  logic signed [SAMPLE_BITS-1:0] next_v,
  input  logic [AGE_BITS-1:0]           next_age,
  output logic signed [SAMPLE_BITS-1:0] v,
  output logic [AGE_BITS-1:0]           age,
  output logic signed [SAMPLE_BITS-1:0] rem_v,
  output logic [AGE_BITS-1:0]           rem_age,
  output logic                          g,
  output logic                          d,
  output logic                          del
);
  import mmf_pkg::*;

  localparam logic [N_BITS-1:0] IDX_N = N_BITS'(IDX);

  logic signed [SAMPLE_BITS-1:0] v_r, v_nxt;
  logic [AGE_BITS-1:0]           age_r, age_nxt;
  logic                          active;
  logic                          tail;
  logic [N_BITS-1:0]             init_age;

  assign active   = IDX_N < n_eff;
  assign tail     = IDX_N >= (n_eff - 1'b1);
  assign del      = active && (N_BITS'(age_r) == (n_eff - 1'b1));
  assign d        = prev_d | del;
  assign rem_v    = d ? next_v : v_r;
  assign rem_age  = d ? next_age : age_r;
  assign g        = tail || (rem_v > x);
  assign init_age = (IDX_N < n_init) ? (n_init - 1'b1 - IDX_N) : '0;

  always_comb begin
    v_nxt   = v_r;
    age_nxt = age_r;
    if (ctl.clear) begin
      v_nxt   = '0;
      age_nxt = AGE_BITS'(init_age);
    end else if (ctl.step && active) begin
      if (g) begin
        if (!prev_g) begin
          v_nxt   = x;
          age_nxt = '0;
        end else begin
          v_nxt   = prev_rem_v;
          age_nxt = AGE_BITS'(prev_rem_age + 1'b1);
        end
      end else begin
        v_nxt   = rem_v;
        age_nxt = AGE_BITS'(rem_age + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    age_r <= age_nxt;
  end

  assign v   = v_r;
  assign age = age_r;

endmodule

// ===== design/moving_median_filter.sv =====
// moving median filter top level: window node chain, median pick and output register
//
// Input channel: in_valid / in_stall / in_sample, one signed sample per transfer.
// Output channel: out_valid / out_stall / out_median_doubled, one result per
// sample, equal to twice the window median (sum of the two middle values when
// the window size is even).
// Configuration: cfg_wr_en with cfg_wr_data writes the window size; values
// below 3 act as 3 and values above MAX_WINDOW act as MAX_WINDOW. A write
// clears the window to zeros and must only happen while the block is idle.
// Every window slot is a node of a chain; on each sample the oldest entry
// leaves and the new sample enters in sorted place.
// The result is registered in the window nodes, then in the output register, before it is offered.
// Throughput: one sample per cycle while the receiver does not stall.
// Reset: synchronous, clears the window to zeros with a window size of 3.
// When the receiver stalls, one finished result waits in the output register
// and one more in the chain; after that in_stall rises until out_stall drops.
`include "moving_median_filter_assert.svh"

module moving_median_filter #(
  parameter int unsigned MAX_WINDOW  = mmf_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [mmf_pkg::WIN_CFG_BITS-1:0]    cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS:0]         out_median_doubled
);
  import mmf_pkg::*;

  localparam int unsigned AGE_BITS = $clog2(MAX_WINDOW);
  localparam int unsigned N_BITS   = $clog2(MAX_WINDOW + 1);

  logic [N_BITS-1:0]             n_eff_r, n_eff_nxt;
  logic [N_BITS-1:0]             n_init;
  logic                          pend_r, pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS:0]   med_r, med_nxt;
  logic                          in_xfer;
  logic                          can_load;
  logic                          load;
  node_ctl_t                     ctl;
  logic [N_BITS-1:0]             hi_idx;
  logic [N_BITS-1:0]             lo_idx;
  logic signed [SAMPLE_BITS-1:0] hi_val;
  logic signed [SAMPLE_BITS-1:0] lo_val;

  logic signed [SAMPLE_BITS-1:0] v_w     [MAX_WINDOW];
  logic [AGE_BITS-1:0]           age_w   [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rem_v_w [MAX_WINDOW];
  logic [AGE_BITS-1:0]           rem_a_w [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         g_w;
  logic [MAX_WINDOW-1:0]         d_w;
  logic [MAX_WINDOW-1:0]         del_w;

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = pend_r && !can_load;
  assign in_xfer  = in_valid && !in_stall;
  assign load     = pend_r && can_load;

  assign n_init    = !rst_n ? N_BITS'(MIN_WINDOW)
                            : N_BITS'(win_clamp(cfg_wr_data, MAX_WINDOW));
  assign ctl.clear = !rst_n || cfg_wr_en;
  assign ctl.step  = in_xfer;

  genvar k;
  generate
    for (k = 0; k < MAX_WINDOW; k++) begin : g_node
      logic signed [SAMPLE_BITS-1:0] p_v;
      logic [AGE_BITS-1:0]           p_a;
      logic                          p_g;
      logic                          p_d;
      logic signed [SAMPLE_BITS-1:0] n_v;
      logic [AGE_BITS-1:0]           n_a;

      if (k == 0) begin : g_head
        assign p_v = '0;
        assign p_a = '0;
        assign p_g = 1'b0;
        assign p_d = 1'b0;
      end else begin : g_link
        assign p_v = rem_v_w[k-1];
        assign p_a = rem_a_w[k-1];
        assign p_g = g_w[k-1];
        assign p_d = d_w[k-1];
      end

      if (k == MAX_WINDOW - 1) begin : g_tail
        assign n_v = '0;
        assign n_a = '0;
      end else begin : g_body
        assign n_v = v_w[k+1];
        assign n_a = age_w[k+1];
      end

      mmf_node #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .AGE_BITS    (AGE_BITS),
        .N_BITS      (N_BITS),
        .IDX         (k)
      ) u_node (
        .clk          (clk),
        .ctl          (ctl),
        .n_eff        (n_eff_r),
        .n_init       (n_init),
        .x            (in_sample),
        .prev_rem_v   (p_v),
        .prev_rem_age (p_a),
        .prev_g       (p_g),
        .prev_d       (p_d),
        .next_v       (n_v),
        .next_age     (n_a),
        .v            (v_w[k]),
        .age          (age_w[k]),
        .rem_v        (rem_v_w[k]),
        .rem_age      (rem_a_w[k]),
        .g            (g_w[k]),
        .d            (d_w[k]),
        .del          (del_w[k])
      );
    end
  endgenerate

  // middle slots of the active window
  assign hi_idx = n_eff_r >> 1;
  assign lo_idx = n_eff_r[0] ? hi_idx : (hi_idx - 1'b1);

  always_comb begin
    hi_val = '0;
    lo_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (N_BITS'(i) == hi_idx) hi_val = hi_val | v_w[i];
      if (N_BITS'(i) == lo_idx) lo_val = lo_val | v_w[i];
    end
  end

  always_comb begin
    n_eff_nxt     = n_eff_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    med_nxt       = med_r;
    if (ctl.clear) begin
      n_eff_nxt = n_init;
    end
    if (load) begin
      med_nxt       = (SAMPLE_BITS + 1)'(hi_val) + (SAMPLE_BITS + 1)'(lo_val);
      out_valid_nxt = 1'b1;
      pend_nxt      = in_xfer;
    end else begin
      if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
      if (in_xfer) pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r     <= N_BITS'(MIN_WINDOW);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_eff_r     <= n_eff_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    med_r <= med_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = med_r;

  `MMF_ASSERT(a_one_oldest, clk, rst_n, $countones(del_w) == 1)
  `MMF_ASSERT(a_stall_when_full, clk, rst_n, (pend_r && out_valid_r && out_stall) |-> in_stall)
  `MMF_ASSERT(a_xfer_pends, clk, rst_n, (in_valid && !in_stall) |=> pend_r)
  `MMF_ASSERT(a_out_drops_on_xfer, clk, rst_n, $fell(out_valid_r) |-> $past(!out_stall))

endmodule

// ===== test/moving_median_filter_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the moving median filter with its own window predictor
module moving_median_filter_tb;
  import mmf_pkg::*;

  localparam int MAX_WIN        = MAX_WINDOW_DEF;
  localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_AT_RESULT = 230;
  localparam int HOLD_CYCLES    = 120;
  localparam int SEGMENT_ITEMS  = 138;
  localparam int SEGMENTS       = 13;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [WIN_CFG_BITS-1:0]     cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SAMPLE_W:0]    out_median_doubled;

  logic signed [SAMPLE_W-1:0]  pending_samples [$];
  logic signed [SAMPLE_W:0]    expected_medians [$];

  logic signed [SAMPLE_W-1:0]  window_ring [MAX_WIN];
  int                          ring_pos;
  logic [WIN_CFG_BITS-1:0]     window_setting;
  logic [WIN_CFG_BITS-1:0]     window_plan [11] = '{6'd0, 6'd63, 6'd32, 6'd4, 6'd2, 6'd33,
                                                    6'd31, 6'd3, 6'd16, 6'd1, 6'd5};

  int                          sender_idle_pct = 0;
  int                          receiver_idle_pct = 0;
  int                          mismatch_count = 0;
  int                          result_count = 0;
  int                          cycle_count = 0;
  int                          hold_left = 0;
  bit                          hold_done = 1'b0;
  logic signed [SAMPLE_W:0]    wanted_median;

  moving_median_filter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_median_doubled (out_median_doubled)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void reset_window_model(logic [WIN_CFG_BITS-1:0] size_bits);
    window_setting = size_bits;
    ring_pos = 0;
    for (int i = 0; i < MAX_WIN; i++) window_ring[i] = '0;
  endfunction

  // ring update, then median of the live window taken from a sorted copy
  function automatic logic signed [SAMPLE_W:0] window_median_after(
    logic signed [SAMPLE_W-1:0] x
  );
    int n;
    int key;
    int j;
    int sorted_vals [MAX_WIN];
    logic signed [SAMPLE_W:0] doubled;
    n = int'(window_setting);
    if (n < MIN_WINDOW) n = MIN_WINDOW;
    if (n > MAX_WIN) n = MAX_WIN;
    if (ring_pos >= n) ring_pos = 0;
    window_ring[ring_pos] = x;
    ring_pos = (ring_pos + 1 >= n) ? 0 : ring_pos + 1;
    for (int i = 0; i < n; i++) begin
      key = int'(window_ring[i]);
      j = i;
      while (j > 0 && sorted_vals[j-1] > key) begin
        sorted_vals[j] = sorted_vals[j-1];
        j--;
      end
      sorted_vals[j] = key;
    end
    if (n % 2 == 1) doubled = (SAMPLE_W + 1)'(2 * sorted_vals[n/2]);
    else doubled = (SAMPLE_W + 1)'(sorted_vals[n/2] + sorted_vals[n/2-1]);
    return doubled;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_random_sample();
    int mode;
    logic signed [SAMPLE_W-1:0] v;
    mode = $urandom_range(6, 0);
    if (mode <= 3) v = SAMPLE_W'($urandom_range(65535, 0));
    else if (mode <= 5) v = SAMPLE_W'($signed($urandom_range(6, 0)) - 3);
    else begin
      case ($urandom_range(3, 0))
        0: v = 16'sh7fff;
        1: v = 16'sh8000;
        2: v = 16'sh8001;
        default: v = 16'sh7ffe;
      endcase
    end
    return v;
  endfunction

  task automatic report_failure(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", what);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_medians.size() != 0) @(posedge clk);
  endtask

  task automatic write_window_size(logic [WIN_CFG_BITS-1:0] size_bits);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size_bits;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reset_window_model(size_bits);
  endtask

  // driver: offers the oldest pending sample, holds it while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_medians.push_back(window_median_after(in_sample));
        void'(pending_samples.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (pending_samples.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_sample <= pending_samples[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer, drives the receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_medians.size() == 0) begin
          report_failure($sformatf("unexpected result %0d", out_median_doubled));
        end else begin
          wanted_median = expected_medians.pop_front();
          if (out_median_doubled !== wanted_median)
            report_failure($sformatf("median mismatch at result %0d: expected %0d got %0d",
                                     result_count, wanted_median, out_median_doubled));
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && result_count >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reset_window_model(WIN_CFG_BITS'(MIN_WINDOW));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 28;
    receiver_idle_pct = 67;

    // start-up zeros, extremes, ties and sign patterns at the reset window
    pending_samples = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sd5, 16'sd5,
                        16'sd5, -16'sd7, 16'sd100, -16'sd100, 16'sh5555,
                        16'shaaaa, 16'sh00ff, 16'shff00, 16'sh8001};
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        sender_idle_pct = 67;
        receiver_idle_pct = 28;
      end
      if (seg == 9) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (seg < 11) write_window_size(window_plan[seg]);
      else write_window_size(WIN_CFG_BITS'($urandom_range(63, 0)));
      repeat (SEGMENT_ITEMS) pending_samples.push_back(next_random_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_medians.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
